>>> rtl/core/acse_pkg.sv
// Package for the AES-128 CFB salted image encrypter.
// Types, constants, S-box and round helper functions. No dependencies.
package acse_pkg;

    localparam int unsigned SALT_START = 32;
    localparam int unsigned SALT_BYTES = 16;

    localparam logic [2:0] REG_KEY_HI  = 3'd0;
    localparam logic [2:0] REG_KEY_LO  = 3'd1;
    localparam logic [2:0] REG_IV_HI   = 3'd2;
    localparam logic [2:0] REG_IV_LO   = 3'd3;
    localparam logic [2:0] REG_SALT_HI = 3'd4;
    localparam logic [2:0] REG_SALT_LO = 3'd5;

    localparam logic [63:0] IV_HI_RESET = 64'h0001020304050607;
    localparam logic [63:0] IV_LO_RESET = 64'h08090a0b0c0d0e0f;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
        logic [4:0]  byte_count;
        logic        final_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
        logic        end_of_image;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic start_image;   // load IV, clear offset, load key
        logic load_block;    // capture plaintext, start AES on feedback
        logic pad_block;     // AES on feedback, plaintext = 16 x 0x10
        logic round_step;    // one AES round
        logic finish;        // xor, update feedback, fill output
        logic end_flag;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_round;
        logic need_pad;      // final block with full byte count
        logic is_final;
    } dp_stat_t;

    typedef logic [7:0] sbox_t [256];
    localparam sbox_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 is bits [127:120]
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                u[i+4*c] = t[i + 4*((c+i) & 3)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!last) begin
                u[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                u[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                u[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                u[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = u[i];
        end
        aes_round = r;
    endfunction

    // next round key from the current one
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

>>> rtl/core/acse_datapath.sv
// AES round datapath: state, on-the-fly key schedule, salt/pad, CFB feedback.
// Depends on acse_pkg.
module acse_datapath
    import acse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    input  in_word_t      in_word,
    input  logic [127:0]  key,
    input  logic [127:0]  iv,
    input  logic [127:0]  salt,
    output out_word_t     out_word
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [127:0] plain_reg, plain_next;
    logic [127:0] fb_reg, fb_next;
    logic [127:0] base_key_reg;
    logic [15:0]  offset_reg, offset_next;
    logic [3:0]   round_reg, round_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         need_pad_reg, need_pad_next;
    logic         final_reg, final_next;
    out_word_t    out_reg, out_next;

    logic [127:0] fb_cur, patched, rnd;
    logic [4:0]   n;
    logic [16:0]  pos;
    logic [3:0]   rel;
    logic [127:0] ks;

    always_comb begin
        fb_cur = cmd.start_image ? iv : fb_reg;
        ks     = cmd.start_image ? key : base_key_reg;
        n      = (in_word.byte_count > 5'd16) ? 5'd16 : in_word.byte_count;
        pos    = '0;
        rel    = '0;
        patched = {in_word.plain_hi, in_word.plain_lo};
        if (in_word.final_block && n < 5'd16) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= n) begin
                    patched[127-8*i -: 8] = 8'(5'd16 - n);
                end
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                pos = {1'b0, cmd.start_image ? 16'd0 : offset_reg} + 17'(i);
                rel = 4'(pos - 17'(SALT_START));
                if (pos >= 17'(SALT_START) && pos - 17'(SALT_START) < 17'(SALT_BYTES)) begin
                    patched[127-8*i -: 8] = salt[127-8*rel -: 8];
                end
            end
        end
        rnd = aes_round(state_reg, round_reg == 4'd10) ^ next_key(rkey_reg, rcon_reg);
    end

    always_comb begin
        state_next    = state_reg;
        rkey_next     = rkey_reg;
        plain_next    = plain_reg;
        fb_next       = fb_reg;
        offset_next   = offset_reg;
        round_next    = round_reg;
        rcon_next     = rcon_reg;
        need_pad_next = need_pad_reg;
        final_next    = final_reg;
        out_next      = out_reg;
        if (cmd.start_image) begin
            fb_next     = iv;
            offset_next = 16'd0;
        end
        if (cmd.load_block) begin
            state_next    = fb_cur ^ ks;
            rkey_next     = ks;
            plain_next    = patched;
            round_next    = 4'd1;
            rcon_next     = 8'h01;
            need_pad_next = in_word.final_block && n == 5'd16;
            final_next    = in_word.final_block;
            if (!(in_word.final_block && n < 5'd16)) begin
                offset_next = (cmd.start_image ? 16'd0 : offset_reg) > 16'd65519 ? 16'hffff
                            : (cmd.start_image ? 16'd0 : offset_reg) + 16'd16;
            end
        end
        if (cmd.pad_block) begin
            // pad block chains on the ciphertext word finished in this cycle
            state_next    = state_reg ^ plain_reg ^ base_key_reg;
            rkey_next     = base_key_reg;
            plain_next    = {16{8'h10}};
            round_next    = 4'd1;
            rcon_next     = 8'h01;
            need_pad_next = 1'b0;
        end
        if (cmd.round_step) begin
            state_next = rnd;
            rkey_next  = next_key(rkey_reg, rcon_reg);
            rcon_next  = xtime(rcon_reg);
            round_next = round_reg + 4'd1;
        end
        if (cmd.finish) begin
            fb_next  = state_reg ^ plain_reg;
            out_next.cipher_hi    = fb_next[127:64];
            out_next.cipher_lo    = fb_next[63:0];
            out_next.end_of_image = cmd.end_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            round_reg    <= 4'd0;
            offset_reg   <= 16'd0;
            need_pad_reg <= 1'b0;
            final_reg    <= 1'b0;
        end else begin
            round_reg    <= round_next;
            offset_reg   <= offset_next;
            need_pad_reg <= need_pad_next;
            final_reg    <= final_next;
        end
    end

    always_ff @(posedge clk) begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        plain_reg <= plain_next;
        fb_reg    <= fb_next;
        rcon_reg  <= rcon_next;
        out_reg   <= out_next;
        if (cmd.start_image) begin
            base_key_reg <= key;
        end
    end

    assign stat.last_round = round_reg == 4'd10;
    assign stat.need_pad   = need_pad_reg;
    assign stat.is_final   = final_reg;
    assign out_word        = out_reg;

endmodule

>>> rtl/core/acse_ctrl.sv
// Sequencer for the encrypter: block load, ten rounds, output, pad block.
// Depends on acse_pkg.
module acse_ctrl
    import acse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       in_image_reg, in_image_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free  = !valid_reg || !out_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = valid_reg;

    always_comb begin
        state_next    = state_reg;
        in_image_next = in_image_reg;
        valid_next    = valid_reg && out_stall;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.start_image = !in_image_reg;
                    cmd.load_block  = 1'b1;
                    in_image_next   = 1'b1;
                    state_next      = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.last_round) begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    cmd.end_flag = stat.is_final && !stat.need_pad;
                    valid_next   = 1'b1;
                    if (stat.need_pad) begin
                        cmd.pad_block = 1'b1;
                        state_next    = S_ROUND;
                    end else begin
                        if (stat.is_final) begin
                            in_image_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            in_image_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_image_reg <= in_image_next;
            valid_reg    <= valid_next;
        end
    end

endmodule

>>> rtl/core/aes128_cfb_salted_encrypter.sv
// AES-128 CFB-128 salted image encrypter, top level.
// One block: a load step, ten AES rounds on the single shared round unit, then an output
// step that waits while the output is stalled; a full final block adds a pad block.
// A new block is taken only after the last one is output. Reset (rst_n, async low) clears control
// and config registers; IV resets to 00 01 .. 0f. Depends on acse_pkg.
module aes128_cfb_salted_encrypter
    import acse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg, salt_hi_reg, salt_lo_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_hi_reg  <= '0;
            key_lo_reg  <= '0;
            iv_hi_reg   <= IV_HI_RESET;
            iv_lo_reg   <= IV_LO_RESET;
            salt_hi_reg <= '0;
            salt_lo_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_HI:  key_hi_reg  <= cfg_data;
                REG_KEY_LO:  key_lo_reg  <= cfg_data;
                REG_IV_HI:   iv_hi_reg   <= cfg_data;
                REG_IV_LO:   iv_lo_reg   <= cfg_data;
                REG_SALT_HI: salt_hi_reg <= cfg_data;
                REG_SALT_LO: salt_lo_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    acse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    acse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_word  (in_word),
        .key      ({key_hi_reg, key_lo_reg}),
        .iv       ({iv_hi_reg, iv_lo_reg}),
        .salt     ({salt_hi_reg, salt_lo_reg}),
        .out_word (out_word)
    );

endmodule

>>> tb/acse_checker.sv
// Checker for the AES-128 CFB salted image encrypter: watches the input,
// output and config channels, predicts each ciphertext word and compares.
// Depends on acse_pkg.
module acse_checker
    import acse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r, salt_hi_r, salt_lo_r;
    logic [127:0] chain;
    logic [31:0]  sched [44];
    int unsigned  offset;
    logic         busy_image;
    out_word_t    cipher_q [$];

    assign pending = cipher_q.size();

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched[0] = key_hi_r[63:32];
        sched[1] = key_hi_r[31:0];
        sched[2] = key_lo_r[63:32];
        sched[3] = key_lo_r[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
                rc = gmul2(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [31:0]  w;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127-8*i -: 8];
        for (int rnd = 0; rnd <= 10; rnd++) begin
            if (rnd > 0) begin
                for (int i = 0; i < 16; i++)
                    t[i] = SBOX[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        s[i+4*c] = t[i + 4*((c+i) % 4)];
                if (rnd != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                        s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                        s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                        s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = sched[rnd*4 + c];
                s[4*c]   ^= w[31:24];
                s[4*c+1] ^= w[23:16];
                s[4*c+2] ^= w[15:8];
                s[4*c+3] ^= w[7:0];
            end
        end
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic void chain_block(input logic [127:0] plain, input logic eoi);
        out_word_t o;
        chain = encrypt(chain) ^ plain;
        o.cipher_hi    = chain[127:64];
        o.cipher_lo    = chain[63:0];
        o.end_of_image = eoi;
        cipher_q.push_back(o);
    endfunction

    function automatic void predict_word(input in_word_t w);
        logic [127:0] p;
        logic [127:0] salt;
        int unsigned  n, pos;
        if (!busy_image) begin
            build_schedule();
            chain      = {iv_hi_r, iv_lo_r};
            offset     = 0;
            busy_image = 1'b1;
        end
        n = (w.byte_count > 16) ? 16 : w.byte_count;
        p = {w.plain_hi, w.plain_lo};
        if (w.final_block && n < 16) begin
            for (int i = 0; i < 16; i++)
                if (i >= n)
                    p[127-8*i -: 8] = 8'(16 - n);
            chain_block(p, 1'b1);
            busy_image = 1'b0;
            return;
        end
        salt = {salt_hi_r, salt_lo_r};
        for (int i = 0; i < 16; i++) begin
            pos = offset + i;
            if (pos >= SALT_START && pos - SALT_START < SALT_BYTES)
                p[127-8*i -: 8] = salt[127-8*((pos - SALT_START) % 16) -: 8];
        end
        chain_block(p, 1'b0);
        offset = (offset + 16 > 65535) ? 65535 : offset + 16;
        if (w.final_block) begin
            chain_block({16{8'h10}}, 1'b1);
            busy_image = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_word_t e;
        if (!rst_n) begin
            key_hi_r     <= '0;
            key_lo_r     <= '0;
            iv_hi_r      <= IV_HI_RESET;
            iv_lo_r      <= IV_LO_RESET;
            salt_hi_r    <= '0;
            salt_lo_r    <= '0;
            busy_image   = 1'b0;
            offset       = 0;
            chain        = '0;
            errors       <= 0;
            results_seen <= 0;
            cipher_q.delete();
        end else begin
            if (out_valid && !out_stall) begin
                results_seen <= results_seen + 1;
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, out_word);
                    errors <= errors + 1;
                end else begin
                    e = cipher_q.pop_front();
                    if (out_word.cipher_hi !== e.cipher_hi || out_word.cipher_lo !== e.cipher_lo
                        || out_word.end_of_image !== e.end_of_image) begin
                        $display("%0t: mismatch expected %h_%h eoi %b actual %h_%h eoi %b",
                                 $time, e.cipher_hi, e.cipher_lo, e.end_of_image,
                                 out_word.cipher_hi, out_word.cipher_lo, out_word.end_of_image);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_word);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_HI:  key_hi_r  <= cfg_data;
                    REG_KEY_LO:  key_lo_r  <= cfg_data;
                    REG_IV_HI:   iv_hi_r   <= cfg_data;
                    REG_IV_LO:   iv_lo_r   <= cfg_data;
                    REG_SALT_HI: salt_hi_r <= cfg_data;
                    REG_SALT_LO: salt_lo_r <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> tb/tb.sv
// Top of the encrypter testbench: clock, reset, stimulus, verdict.
// Drives images and config writes; acse_checker predicts and compares.
// Depends on acse_pkg, acse_checker and aes128_cfb_salted_encrypter.
module tb
    import acse_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors, pending, results_seen;
    bit          idle_on;
    bit          hold_req;
    int          words_sent, images_sent;

    aes128_cfb_salted_encrypter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    acse_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver backpressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic fin);
        in_word_t w;
        w.plain_hi    = hi;
        w.plain_lo    = lo;
        w.byte_count  = cnt;
        w.final_block = fin;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_image(input int blocks, input logic [4:0] last_cnt);
        for (int i = 1; i < blocks; i++)
            send_word(rnd64(), rnd64(), 5'($urandom_range(0, 31)), 1'b0);
        send_word(rnd64(), rnd64(), last_cnt, 1'b1);
        images_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // leaves cfg_valid high; caller lowers it after the last write
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_all(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] ih, input logic [63:0] il,
                            input logic [63:0] sh, input logic [63:0] sl);
        drain();
        cfg_write(REG_KEY_HI, kh);
        cfg_write(REG_KEY_LO, kl);
        cfg_write(REG_IV_HI, ih);
        cfg_write(REG_IV_LO, il);
        cfg_write(REG_SALT_HI, sh);
        cfg_write(REG_SALT_LO, sl);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [4:0] last_count();
        case ($urandom_range(0, 3))
            0: return 5'd16;
            1: return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(0, 15));
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_HI;
        cfg_data  = '0;
        idle_on   = 1'b0;
        hold_req  = 1'b0;
        words_sent  = 0;
        images_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset config: salted full blocks, full last block with pad block
        send_word('0, '0, 5'd0, 1'b0);
        send_word('1, '1, 5'd31, 1'b0);
        send_word(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7, 1'b0);
        send_word('1, '1, 5'd16, 1'b1);
        images_sent++;
        send_word('1, '0, 5'd0, 1'b1);
        send_word('0, '1, 5'd15, 1'b1);
        send_word(rnd64(), rnd64(), 5'd1, 1'b1);
        send_word(rnd64(), rnd64(), 5'd17, 1'b1);
        send_word('1, '1, 5'd31, 1'b1);
        images_sent += 5;
        send_image(4, 5'd8);

        load_all('1, '1, '0, '0, '1, '1);
        send_image(4, 5'd16);
        send_image(3, 5'd0);
        send_image(1, 5'd16);
        load_all(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1,
                 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_image(5, 5'd12);

        // long receiver hold while the sender keeps offering
        hold_req = 1'b1;
        send_image(40, 5'd16);
        drain();

        idle_on = 1'b1;
        while (words_sent < 460)
        begin
            if ($urandom_range(0, 5) == 0)
                load_all(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
            if ($urandom_range(0, 12) == 0)
            begin
                hold_req = 1'b1;
                send_image(60, last_count());
                drain();
            end
            else
                send_image($urandom_range(1, 8), last_count());
        end

        idle_on = 1'b0;
        repeat (20) send_image($urandom_range(1, 5), last_count());

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d input words in %0d images, %0d ciphertext words checked.",
                 words_sent, images_sent, results_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/acse_pkg.sv
rtl/core/acse_datapath.sv
rtl/core/acse_ctrl.sv
rtl/core/aes128_cfb_salted_encrypter.sv
tb/acse_checker.sv
tb/tb.sv
